// ===== rtl/core/usbep0_pkg.sv =====
// usbep0_pkg: codes and types for the endpoint-0 standard request handler
// no dependencies; imported by usb_ep0_request_handler
`default_nettype none

package usbep0_pkg;

  // event codes on the input channel
  localparam logic [2:0] EV_BUS_RESET   = 3'd0;
  localparam logic [2:0] EV_SETUP_DATA  = 3'd1;
  localparam logic [2:0] EV_SETUP_TOKEN = 3'd2;
  localparam logic [2:0] EV_IN_DONE     = 3'd3;
  localparam logic [2:0] EV_OUT_DONE    = 3'd4;

  // action codes on the result channel
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_LOAD  = 3'd1;
  localparam logic [2:0] ACT_ZLP   = 3'd2;
  localparam logic [2:0] ACT_HS    = 3'd3;
  localparam logic [2:0] ACT_STALL = 3'd4;
  localparam logic [2:0] ACT_ARM   = 3'd5;

  // device states
  localparam logic [1:0] ST_DEFAULT    = 2'd0;
  localparam logic [1:0] ST_ADDRESSED  = 2'd1;
  localparam logic [1:0] ST_CONFIGURED = 2'd2;

  // data sources for IN loads
  localparam logic [3:0] SRC_LITERAL = 4'd0;
  localparam logic [3:0] SRC_DEVICE  = 4'd1;
  localparam logic [3:0] SRC_CONFIG  = 4'd2;
  localparam logic [3:0] SRC_LANG    = 4'd3;
  localparam logic [3:0] SRC_STR1    = 4'd4;
  localparam logic [3:0] SRC_STR2    = 4'd5;
  localparam logic [3:0] SRC_OS_STR  = 4'd6;
  localparam logic [3:0] SRC_COMPAT  = 4'd7;
  localparam logic [3:0] SRC_PROPS   = 4'd8;

  // configuration register indexes
  localparam int unsigned NUM_REGS = 8;
  localparam logic [2:0] REG_DEVICE_LEN = 3'd0;
  localparam logic [2:0] REG_CONFIG_LEN = 3'd1;
  localparam logic [2:0] REG_LANG_LEN   = 3'd2;
  localparam logic [2:0] REG_STR1_LEN   = 3'd3;
  localparam logic [2:0] REG_STR2_LEN   = 3'd4;
  localparam logic [2:0] REG_OS_STR_LEN = 3'd5;
  localparam logic [2:0] REG_COMPAT_LEN = 3'd6;
  localparam logic [2:0] REG_PROPS_LEN  = 3'd7;

  // standard request codes
  localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
  localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE  = 8'd10;

  // descriptor types
  localparam logic [7:0] DT_DEVICE     = 8'd1;
  localparam logic [7:0] DT_CONFIG     = 8'd2;
  localparam logic [7:0] DT_STRING     = 8'd3;
  localparam logic [7:0] DT_INTERFACE  = 8'd4;
  localparam logic [7:0] DT_IF_POWER   = 8'd8;

  // string indexes
  localparam logic [7:0] STR_LANG   = 8'h00;
  localparam logic [7:0] STR_ONE    = 8'h01;
  localparam logic [7:0] STR_TWO    = 8'h02;
  localparam logic [7:0] STR_OS     = 8'hEE;

  // bmRequestType fields and values
  localparam logic [7:0] RT_TYPE_MASK     = 8'h60;
  localparam logic [7:0] RT_TYPE_STANDARD = 8'h00;
  localparam logic [7:0] RT_TYPE_CLASS    = 8'h20;
  localparam logic [7:0] RT_DIR_IN        = 8'h80;
  localparam logic [7:0] RT_VENDOR_DEV    = 8'hC0;
  localparam logic [7:0] RT_VENDOR_IF     = 8'hC1;
  localparam logic [7:0] RT_STD_IN_DEV    = 8'h80;
  localparam logic [7:0] RT_STD_IN_IF     = 8'h81;
  localparam logic [7:0] RT_STD_IN_EP     = 8'h82;

  // one endpoint-0 event as held in the input register
  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] request_kind;
    logic [7:0] request_code;
    logic [7:0] value_low;
    logic [7:0] value_high;
    logic [7:0] index_low;
    logic [7:0] length_low;
    logic [7:0] in_ep_status;
    logic [7:0] out_ep_status;
  } ep0_event_t;

  // one result as held in the output register
  typedef struct packed {
    logic [2:0] action;
    logic [6:0] byte_count;
    logic [3:0] data_source;
    logic [7:0] source_offset;
    logic [7:0] literal_byte;
    logic [1:0] device_state;
  } ep0_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/usb_ep0_request_handler.sv =====
// usb_ep0_request_handler: endpoint-0 request decoder and descriptor packetizer
// one event per transfer in, one action per transfer out
// depends on usbep0_pkg
//
// Usage: each input transfer is one endpoint-0 event (bus reset, setup data,
// setup token, IN done, OUT done, other). Each event yields exactly one
// output transfer naming the action for the endpoint-0 hardware: load IN
// bytes (count, source descriptor, offset, literal byte), zero-length then
// handshake, handshake, stall or arm OUT, plus the device state after it.
// Descriptor lengths come from eight 8-bit registers written through the
// cfg_ port; write them only while no event is in flight.
// Each event lands in an input register, is decoded against the device and
// packetizer state, and the action is registered. Throughput is one event
// per cycle while the result is taken, set by the single decode stage.
// Reset clears the device state, the packetizer, both pipeline valids and
// reloads the register defaults. When out_ready is low the result is held
// and one more event may wait in the input register before in_ready drops.
`default_nettype none

module usb_ep0_request_handler
  import usbep0_pkg::*;
#(
  parameter int EP0_PACKET  = 64,
  parameter int VENDOR_CODE = 170
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration port
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  // event channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_req_type,
  input  wire logic [7:0] in_request_kind,
  input  wire logic [7:0] in_request_code,
  input  wire logic [7:0] in_value_low,
  input  wire logic [7:0] in_value_high,
  input  wire logic [7:0] in_index_low,
  input  wire logic [7:0] in_length_low,
  input  wire logic [7:0] in_in_ep_status,
  input  wire logic [7:0] in_out_ep_status,
  // action channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_action,
  output logic [6:0]      out_byte_count,
  output logic [3:0]      out_data_source,
  output logic [7:0]      out_source_offset,
  output logic [7:0]      out_literal_byte,
  output logic [1:0]      out_device_state
);

  localparam logic [6:0] CHUNK       = 7'(EP0_PACKET);
  localparam logic [7:0] VENDOR_BYTE = 8'(VENDOR_CODE);

  logic [7:0]  cfg_r [NUM_REGS];

  logic        ev_valid_r;
  ep0_event_t  ev_r;
  logic        res_valid_r;
  ep0_result_t res_r;
  ep0_result_t res_nxt;

  logic [1:0]  dev_state_r, dev_state_nxt;
  logic        active_cfg_r, active_cfg_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  send_offset_r, send_offset_nxt;
  logic [3:0]  send_source_r, send_source_nxt;
  logic [6:0]  chunk_limit_r, chunk_limit_nxt;

  logic        ev_fire;
  logic        do_step;
  logic        do_start;
  logic [3:0]  start_src;
  logic [7:0]  start_len;
  logic [7:0]  pk_left;
  logic [7:0]  pk_off;
  logic [3:0]  pk_src;
  logic [6:0]  pk_chunk;
  logic [7:0]  pk_n;

  assign ev_fire  = ev_valid_r && (!res_valid_r || out_ready);
  assign in_ready = !ev_valid_r || ev_fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[REG_DEVICE_LEN] <= 8'd18;
      cfg_r[REG_CONFIG_LEN] <= 8'd32;
      cfg_r[REG_LANG_LEN]   <= 8'd4;
      cfg_r[REG_STR1_LEN]   <= 8'd0;
      cfg_r[REG_STR2_LEN]   <= 8'd0;
      cfg_r[REG_OS_STR_LEN] <= 8'd18;
      cfg_r[REG_COMPAT_LEN] <= 8'd40;
      cfg_r[REG_PROPS_LEN]  <= 8'd0;
    end else if (cfg_wr_en) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else if (in_ready) begin
      ev_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev_r.req_type      <= in_req_type;
      ev_r.request_kind  <= in_request_kind;
      ev_r.request_code  <= in_request_code;
      ev_r.value_low     <= in_value_low;
      ev_r.value_high    <= in_value_high;
      ev_r.index_low     <= in_index_low;
      ev_r.length_low    <= in_length_low;
      ev_r.in_ep_status  <= in_in_ep_status;
      ev_r.out_ep_status <= in_out_ep_status;
    end
  end

  // event decode
  always_comb begin
    dev_state_nxt   = dev_state_r;
    active_cfg_nxt  = active_cfg_r;
    bytes_left_nxt  = bytes_left_r;
    send_offset_nxt = send_offset_r;
    send_source_nxt = send_source_r;
    chunk_limit_nxt = chunk_limit_r;
    res_nxt         = '0;
    res_nxt.action  = ACT_NONE;
    do_step         = 1'b0;
    do_start        = 1'b0;
    start_src       = SRC_LITERAL;
    start_len       = 8'd0;

    case (ev_r.req_type)
      EV_BUS_RESET: begin
        dev_state_nxt  = ST_DEFAULT;
        active_cfg_nxt = 1'b0;
      end
      EV_SETUP_DATA: begin
        if ((ev_r.request_kind & RT_TYPE_MASK) == RT_TYPE_STANDARD) begin
          case (ev_r.request_code)
            REQ_GET_DESCRIPTOR: begin
              chunk_limit_nxt = CHUNK;
              case (ev_r.value_high)
                DT_DEVICE: begin
                  do_start  = 1'b1;
                  start_src = SRC_DEVICE;
                  start_len = cfg_r[REG_DEVICE_LEN];
                end
                DT_CONFIG: begin
                  do_start  = 1'b1;
                  start_src = SRC_CONFIG;
                  start_len = cfg_r[REG_CONFIG_LEN];
                end
                DT_STRING: begin
                  case (ev_r.value_low)
                    STR_LANG: begin
                      do_start  = 1'b1;
                      start_src = SRC_LANG;
                      start_len = cfg_r[REG_LANG_LEN];
                    end
                    STR_ONE: begin
                      do_start  = 1'b1;
                      start_src = SRC_STR1;
                      start_len = cfg_r[REG_STR1_LEN];
                    end
                    STR_TWO: begin
                      do_start  = 1'b1;
                      start_src = SRC_STR2;
                      start_len = cfg_r[REG_STR2_LEN];
                    end
                    STR_OS: begin
                      do_start  = 1'b1;
                      start_src = SRC_OS_STR;
                      start_len = cfg_r[REG_OS_STR_LEN];
                    end
                    default: res_nxt.action = ACT_STALL;
                  endcase
                end
                default: begin
                  // interface through interface-power types stall
                  if (ev_r.value_high >= DT_INTERFACE && ev_r.value_high <= DT_IF_POWER) begin
                    res_nxt.action = ACT_STALL;
                  end else begin
                    res_nxt.action = ACT_HS;
                  end
                end
              endcase
            end
            REQ_GET_STATUS: begin
              if (dev_state_r == ST_ADDRESSED && ev_r.index_low == 8'd0) begin
                res_nxt.action     = ACT_LOAD;
                res_nxt.byte_count = 7'd2;
              end else if (dev_state_r == ST_CONFIGURED) begin
                if (ev_r.request_kind == RT_STD_IN_DEV || ev_r.request_kind == RT_STD_IN_IF) begin
                  res_nxt.action     = ACT_LOAD;
                  res_nxt.byte_count = 7'd2;
                end else if (ev_r.request_kind == RT_STD_IN_EP) begin
                  res_nxt.action       = ACT_LOAD;
                  res_nxt.byte_count   = 7'd2;
                  res_nxt.literal_byte = ev_r.index_low[7] ? ev_r.in_ep_status
                                                           : ev_r.out_ep_status;
                end else begin
                  res_nxt.action = ACT_STALL;
                end
              end else begin
                res_nxt.action = ACT_STALL;
              end
            end
            REQ_SET_ADDRESS: begin
              // status stage is handled by the endpoint hardware
              dev_state_nxt  = ST_ADDRESSED;
              active_cfg_nxt = 1'b0;
            end
            REQ_GET_CONFIG: begin
              if (dev_state_r == ST_ADDRESSED) begin
                res_nxt.action     = ACT_LOAD;
                res_nxt.byte_count = 7'd1;
              end else if (dev_state_r == ST_CONFIGURED) begin
                res_nxt.action       = ACT_LOAD;
                res_nxt.byte_count   = 7'd1;
                res_nxt.literal_byte = {7'd0, active_cfg_r};
              end else begin
                res_nxt.action = ACT_STALL;
              end
            end
            REQ_SET_CONFIG: begin
              if (ev_r.value_low == 8'd0) begin
                dev_state_nxt  = ST_ADDRESSED;
                active_cfg_nxt = 1'b0;
                res_nxt.action = ACT_HS;
              end else if (ev_r.value_low == 8'd1) begin
                dev_state_nxt  = ST_CONFIGURED;
                active_cfg_nxt = 1'b1;
                res_nxt.action = ACT_HS;
              end else begin
                res_nxt.action = ACT_STALL;
              end
            end
            REQ_GET_INTERFACE: begin
              res_nxt.action     = ACT_LOAD;
              res_nxt.byte_count = 7'd1;
            end
            default: res_nxt.action = ACT_STALL;
          endcase
        end else if ((ev_r.request_kind & RT_TYPE_MASK) == RT_TYPE_CLASS) begin
          if (ev_r.length_low != 8'd0 && (ev_r.request_kind & RT_DIR_IN) == 8'd0) begin
            res_nxt.action = ACT_ARM;
          end else begin
            res_nxt.action = ACT_HS;
          end
        end else if (ev_r.request_kind == RT_VENDOR_DEV && ev_r.request_code == VENDOR_BYTE) begin
          do_start  = 1'b1;
          start_src = SRC_COMPAT;
          start_len = cfg_r[REG_COMPAT_LEN];
        end else if (ev_r.request_kind == RT_VENDOR_IF && ev_r.request_code == VENDOR_BYTE) begin
          do_start  = 1'b1;
          start_src = SRC_PROPS;
          start_len = cfg_r[REG_PROPS_LEN];
        end else begin
          res_nxt.action = ACT_STALL;
        end
      end
      EV_SETUP_TOKEN: begin
        bytes_left_nxt  = 8'd0;
        send_offset_nxt = 8'd0;
        send_source_nxt = SRC_LITERAL;
        chunk_limit_nxt = 7'd0;
      end
      EV_IN_DONE: begin
        do_step = 1'b1;
      end
      EV_OUT_DONE: begin
        bytes_left_nxt = 8'd0;
        res_nxt.action = ACT_HS;
      end
      default: res_nxt.action = ACT_NONE;
    endcase

    // packetizer: a fresh start or the next chunk of the current transfer
    if (do_start) begin
      pk_left  = (ev_r.length_low < start_len) ? ev_r.length_low : start_len;
      pk_off   = 8'd0;
      pk_src   = start_src;
      pk_chunk = CHUNK;
    end else begin
      pk_left  = bytes_left_r;
      pk_off   = send_offset_r;
      pk_src   = send_source_r;
      pk_chunk = chunk_limit_r;
    end
    pk_n = (pk_left < {1'b0, pk_chunk}) ? pk_left : {1'b0, pk_chunk};

    if (do_start || do_step) begin
      chunk_limit_nxt = pk_chunk;
      send_source_nxt = pk_src;
      if (pk_left == 8'd0) begin
        bytes_left_nxt  = 8'd0;
        send_offset_nxt = pk_off;
        res_nxt.action  = ACT_ZLP;
      end else begin
        bytes_left_nxt        = pk_left - pk_n;
        send_offset_nxt       = pk_off + pk_n;
        res_nxt.action        = ACT_LOAD;
        res_nxt.byte_count    = pk_n[6:0];
        res_nxt.data_source   = pk_src;
        res_nxt.source_offset = pk_off;
      end
    end

    res_nxt.device_state = dev_state_nxt;
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_state_r   <= ST_DEFAULT;
      active_cfg_r  <= 1'b0;
      bytes_left_r  <= 8'd0;
      send_offset_r <= 8'd0;
      send_source_r <= SRC_LITERAL;
      chunk_limit_r <= 7'd0;
      res_valid_r   <= 1'b0;
    end else begin
      if (ev_fire) begin
        dev_state_r   <= dev_state_nxt;
        active_cfg_r  <= active_cfg_nxt;
        bytes_left_r  <= bytes_left_nxt;
        send_offset_r <= send_offset_nxt;
        send_source_r <= send_source_nxt;
        chunk_limit_r <= chunk_limit_nxt;
      end
      if (ev_fire) begin
        res_valid_r <= 1'b1;
      end else if (out_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = res_valid_r;
  assign out_action        = res_r.action;
  assign out_byte_count    = res_r.byte_count;
  assign out_data_source   = res_r.data_source;
  assign out_source_offset = res_r.source_offset;
  assign out_literal_byte  = res_r.literal_byte;
  assign out_device_state  = res_r.device_state;

  // a load never exceeds one endpoint-0 packet
  a_load_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == ACT_LOAD) |-> (out_byte_count <= CHUNK))
    else $error("load larger than one packet");

  // only a load carries payload fields
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action != ACT_LOAD) |->
      (out_byte_count == 7'd0 && out_data_source == SRC_LITERAL &&
       out_source_offset == 8'd0 && out_literal_byte == 8'd0))
    else $error("payload fields set on a non-load action");

  // a descriptor load carries no literal byte
  a_desc_no_literal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data_source != SRC_LITERAL) |-> (out_literal_byte == 8'd0))
    else $error("literal byte on a descriptor load");

  // the packetizer offset only moves forward by what was just loaded
  a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(ev_fire) && $past(ev_r.req_type) == EV_IN_DONE && $past(rst_n))
      |-> (send_offset_r == 8'($past(send_offset_r) + {1'b0, res_r.byte_count})))
    else $error("packetizer offset out of step with the load");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench for usb_ep0_request_handler: directed and random endpoint-0 events,
// with every action predicted in a scoreboard class and checked field by field
// depends on usbep0_pkg and the usb_ep0_request_handler rtl
`default_nettype none

module testbench
  import usbep0_pkg::*;
();

  localparam int EP0_MAX_PACKET = 64;
  localparam logic [7:0] VENDOR_REQ = 8'd170;
  localparam logic [2:0] EV_FRAME = 3'd5;
  localparam logic [2:0] EV_OTHER = 3'd6;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_PHASES = 8;
  localparam int EVENTS_PER_PHASE = 244;

  // predicts the action of each accepted event and checks the actions that come out
  class ep0_action_scoreboard;
    logic [7:0] desc_len [NUM_REGS];
    logic [1:0] dev_state;
    logic       active_cfg;
    logic [7:0] bytes_left;
    logic [7:0] send_offset;
    logic [3:0] send_source;
    logic [6:0] chunk_limit;
    ep0_result_t pending_actions [$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      desc_len[REG_DEVICE_LEN] = 8'd18;
      desc_len[REG_CONFIG_LEN] = 8'd32;
      desc_len[REG_LANG_LEN]   = 8'd4;
      desc_len[REG_STR1_LEN]   = 8'd0;
      desc_len[REG_STR2_LEN]   = 8'd0;
      desc_len[REG_OS_STR_LEN] = 8'd18;
      desc_len[REG_COMPAT_LEN] = 8'd40;
      desc_len[REG_PROPS_LEN]  = 8'd0;
      dev_state = ST_DEFAULT;
      active_cfg = 1'b0;
      bytes_left = '0;
      send_offset = '0;
      send_source = SRC_LITERAL;
      chunk_limit = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_len(logic [2:0] idx, logic [7:0] len);
      desc_len[idx] = len;
    endfunction

    function int pending_count();
      return pending_actions.size();
    endfunction

    function ep0_result_t next_chunk();
      ep0_result_t r;
      logic [7:0] n;
      r = '0;
      if (bytes_left == 8'd0) begin
        r.action = ACT_ZLP;
      end else begin
        n = (bytes_left < {1'b0, chunk_limit}) ? bytes_left : {1'b0, chunk_limit};
        r.action = ACT_LOAD;
        r.byte_count = n[6:0];
        r.data_source = send_source;
        r.source_offset = send_offset;
        send_offset = send_offset + n;
        bytes_left = bytes_left - n;
      end
      return r;
    endfunction

    function ep0_result_t start_chunks(logic [3:0] src, logic [7:0] len, logic [7:0] want);
      chunk_limit = 7'(EP0_MAX_PACKET & 8'h7F);
      send_source = src;
      send_offset = '0;
      bytes_left = (want < len) ? want : len;
      return next_chunk();
    endfunction

    function ep0_result_t descriptor_reply(ep0_event_t ev);
      ep0_result_t r;
      r = '0;
      chunk_limit = 7'(EP0_MAX_PACKET & 8'h7F);
      if (ev.value_high == DT_DEVICE) begin
        r = start_chunks(SRC_DEVICE, desc_len[REG_DEVICE_LEN], ev.length_low);
      end else if (ev.value_high == DT_CONFIG) begin
        r = start_chunks(SRC_CONFIG, desc_len[REG_CONFIG_LEN], ev.length_low);
      end else if (ev.value_high == DT_STRING) begin
        case (ev.value_low)
          STR_LANG: r = start_chunks(SRC_LANG, desc_len[REG_LANG_LEN], ev.length_low);
          STR_ONE:  r = start_chunks(SRC_STR1, desc_len[REG_STR1_LEN], ev.length_low);
          STR_TWO:  r = start_chunks(SRC_STR2, desc_len[REG_STR2_LEN], ev.length_low);
          STR_OS:   r = start_chunks(SRC_OS_STR, desc_len[REG_OS_STR_LEN], ev.length_low);
          default:  r.action = ACT_STALL;
        endcase
      end else if (ev.value_high >= DT_INTERFACE && ev.value_high <= DT_IF_POWER) begin
        r.action = ACT_STALL;
      end else begin
        r.action = ACT_HS;
      end
      return r;
    endfunction

    function ep0_result_t status_reply(ep0_event_t ev);
      ep0_result_t r;
      r = '0;
      r.action = ACT_STALL;
      if (dev_state == ST_ADDRESSED && ev.index_low == 8'd0) begin
        r.action = ACT_LOAD;
        r.byte_count = 7'd2;
      end else if (dev_state == ST_CONFIGURED) begin
        if (ev.request_kind == RT_STD_IN_DEV || ev.request_kind == RT_STD_IN_IF) begin
          r.action = ACT_LOAD;
          r.byte_count = 7'd2;
        end else if (ev.request_kind == RT_STD_IN_EP) begin
          r.action = ACT_LOAD;
          r.byte_count = 7'd2;
          // bit 7 of the index picks the IN side
          r.literal_byte = ev.index_low[7] ? ev.in_ep_status : ev.out_ep_status;
        end
      end
      return r;
    endfunction

    function ep0_result_t standard_reply(ep0_event_t ev);
      ep0_result_t r;
      r = '0;
      case (ev.request_code)
        REQ_GET_DESCRIPTOR: r = descriptor_reply(ev);
        REQ_GET_STATUS:     r = status_reply(ev);
        REQ_SET_ADDRESS: begin
          // status stage runs on its own, so nothing to do here
          dev_state = ST_ADDRESSED;
          active_cfg = 1'b0;
          r.action = ACT_NONE;
        end
        REQ_GET_CONFIG: begin
          if (dev_state == ST_DEFAULT) begin
            r.action = ACT_STALL;
          end else begin
            r.action = ACT_LOAD;
            r.byte_count = 7'd1;
            if (dev_state == ST_CONFIGURED) r.literal_byte = {7'd0, active_cfg};
          end
        end
        REQ_SET_CONFIG: begin
          if (ev.value_low == 8'd0) begin
            dev_state = ST_ADDRESSED;
            active_cfg = 1'b0;
            r.action = ACT_HS;
          end else if (ev.value_low == 8'd1) begin
            dev_state = ST_CONFIGURED;
            active_cfg = 1'b1;
            r.action = ACT_HS;
          end else begin
            r.action = ACT_STALL;
          end
        end
        REQ_GET_INTERFACE: begin
          r.action = ACT_LOAD;
          r.byte_count = 7'd1;
        end
        default: r.action = ACT_STALL;
      endcase
      return r;
    endfunction

    function ep0_result_t setup_reply(ep0_event_t ev);
      ep0_result_t r;
      r = '0;
      if ((ev.request_kind & RT_TYPE_MASK) == RT_TYPE_STANDARD) begin
        r = standard_reply(ev);
      end else if ((ev.request_kind & RT_TYPE_MASK) == RT_TYPE_CLASS) begin
        r.action = (ev.length_low != 8'd0 && (ev.request_kind & RT_DIR_IN) == 8'd0) ?
                   ACT_ARM : ACT_HS;
      end else if (ev.request_kind == RT_VENDOR_DEV && ev.request_code == VENDOR_REQ) begin
        r = start_chunks(SRC_COMPAT, desc_len[REG_COMPAT_LEN], ev.length_low);
      end else if (ev.request_kind == RT_VENDOR_IF && ev.request_code == VENDOR_REQ) begin
        r = start_chunks(SRC_PROPS, desc_len[REG_PROPS_LEN], ev.length_low);
      end else begin
        r.action = ACT_STALL;
      end
      return r;
    endfunction

    function void note_event(ep0_event_t ev);
      ep0_result_t r;
      r = '0;
      case (ev.req_type)
        EV_BUS_RESET: begin
          // packetizer survives a bus reset
          dev_state = ST_DEFAULT;
          active_cfg = 1'b0;
        end
        EV_SETUP_DATA: r = setup_reply(ev);
        EV_SETUP_TOKEN: begin
          bytes_left = '0;
          send_offset = '0;
          send_source = SRC_LITERAL;
          chunk_limit = '0;
        end
        EV_IN_DONE: r = next_chunk();
        EV_OUT_DONE: begin
          bytes_left = '0;
          r.action = ACT_HS;
        end
        default: r.action = ACT_NONE;
      endcase
      r.device_state = dev_state;
      pending_actions.push_back(r);
    endfunction

    function void compare_field(string what, logic [7:0] exp_v, logic [7:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_action(ep0_result_t got);
      ep0_result_t exp_r;
      if (pending_actions.size() == 0) begin
        $display("%0t: action %0d with nothing expected", $time, got.action);
        mismatches++;
        return;
      end
      exp_r = pending_actions.pop_front();
      checked++;
      compare_field("action", 8'(exp_r.action), 8'(got.action));
      compare_field("byte_count", 8'(exp_r.byte_count), 8'(got.byte_count));
      compare_field("data_source", 8'(exp_r.data_source), 8'(got.data_source));
      compare_field("source_offset", exp_r.source_offset, got.source_offset);
      compare_field("literal_byte", exp_r.literal_byte, got.literal_byte);
      compare_field("device_state", 8'(exp_r.device_state), 8'(got.device_state));
    endfunction

    function void report_leftovers();
      if (pending_actions.size() != 0) begin
        $display("%0t: %0d expected actions never arrived", $time, pending_actions.size());
        mismatches += pending_actions.size();
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_req_type = '0;
  logic [7:0] in_request_kind = '0;
  logic [7:0] in_request_code = '0;
  logic [7:0] in_value_low = '0;
  logic [7:0] in_value_high = '0;
  logic [7:0] in_index_low = '0;
  logic [7:0] in_length_low = '0;
  logic [7:0] in_in_ep_status = '0;
  logic [7:0] in_out_ep_status = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_action;
  logic [6:0] out_byte_count;
  logic [3:0] out_data_source;
  logic [7:0] out_source_offset;
  logic [7:0] out_literal_byte;
  logic [1:0] out_device_state;

  ep0_action_scoreboard board;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned events_sent = 0;
  int unsigned events_ignored = 0;
  int unsigned settings_used = 0;
  int unsigned idle_cycles = 0;
  logic [7:0] len_plan [NUM_REGS];

  usb_ep0_request_handler #(
    .EP0_PACKET (EP0_MAX_PACKET),
    .VENDOR_CODE(170)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_request_kind  (in_request_kind),
    .in_request_code  (in_request_code),
    .in_value_low     (in_value_low),
    .in_value_high    (in_value_high),
    .in_index_low     (in_index_low),
    .in_length_low    (in_length_low),
    .in_in_ep_status  (in_in_ep_status),
    .in_out_ep_status (in_out_ep_status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_action       (out_action),
    .out_byte_count   (out_byte_count),
    .out_data_source  (out_data_source),
    .out_source_offset(out_source_offset),
    .out_literal_byte (out_literal_byte),
    .out_device_state (out_device_state)
  );

  always #10 clk = ~clk;

  // action side: check each transfer, then pick the next ready
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        board.check_action({out_action, out_byte_count, out_data_source,
                            out_source_offset, out_literal_byte, out_device_state});
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic ep0_event_t random_event();
    ep0_event_t ev;
    ev.req_type = 3'($urandom_range(6));
    ev.request_kind = 8'($urandom);
    ev.request_code = 8'($urandom);
    ev.value_low = 8'($urandom);
    ev.value_high = 8'($urandom);
    ev.index_low = 8'($urandom);
    ev.length_low = 8'($urandom);
    ev.in_ep_status = 8'($urandom);
    ev.out_ep_status = 8'($urandom);
    return ev;
  endfunction

  function automatic ep0_event_t bus_event(logic [2:0] kind_of_event);
    ep0_event_t ev;
    ev = random_event();
    ev.req_type = kind_of_event;
    return ev;
  endfunction

  function automatic ep0_event_t setup_req(logic [7:0] kind, logic [7:0] code,
                                           logic [7:0] vl, logic [7:0] vh,
                                           logic [7:0] idx, logic [7:0] len);
    ep0_event_t ev;
    ev = bus_event(EV_SETUP_DATA);
    ev.request_kind = kind;
    ev.request_code = code;
    ev.value_low = vl;
    ev.value_high = vh;
    ev.index_low = idx;
    ev.length_low = len;
    return ev;
  endfunction

  task automatic send_event(input ep0_event_t ev);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= ev.req_type;
    in_request_kind <= ev.request_kind;
    in_request_code <= ev.request_code;
    in_value_low <= ev.value_low;
    in_value_high <= ev.value_high;
    in_index_low <= ev.index_low;
    in_length_low <= ev.length_low;
    in_in_ep_status <= ev.in_ep_status;
    in_out_ep_status <= ev.out_ep_status;
    do @(posedge clk); while (!in_ready);
    board.note_event(ev);
    if (ev.req_type <= EV_OUT_DONE) events_sent++;
    else events_ignored++;
  endtask

  // stop sending and wait until every predicted action has come out
  task automatic drain_actions();
    in_valid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_desc_lengths();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= len_plan[i];
      @(posedge clk);
      board.set_len(3'(i), len_plan[i]);
    end
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [7:0] std_kind();
    return ($urandom_range(3) == 0) ? (8'($urandom) & ~RT_TYPE_MASK) : RT_STD_IN_DEV;
  endfunction

  // one short host exchange, mostly well formed, some of it noise
  task automatic random_session();
    int pick;
    logic [7:0] vh;
    logic [7:0] vl;
    logic [7:0] kind;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_event(bus_event(EV_SETUP_TOKEN));
      case ($urandom_range(5))
        0: vh = DT_DEVICE;
        1: vh = DT_CONFIG;
        2, 3: vh = DT_STRING;
        4: vh = 8'($urandom_range(DT_INTERFACE, DT_IF_POWER));
        default: vh = 8'($urandom);
      endcase
      case ($urandom_range(4))
        0: vl = STR_LANG;
        1: vl = STR_ONE;
        2: vl = STR_TWO;
        3: vl = STR_OS;
        default: vl = 8'($urandom);
      endcase
      send_event(setup_req(std_kind(), REQ_GET_DESCRIPTOR, vl, vh, 8'($urandom),
                           8'($urandom)));
      repeat ($urandom_range(6)) send_event(bus_event(EV_IN_DONE));
      if ($urandom_range(3) != 0) send_event(bus_event(EV_OUT_DONE));
    end else if (pick < 50) begin
      send_event(bus_event(EV_SETUP_TOKEN));
      kind = $urandom_range(1) ? RT_VENDOR_DEV : RT_VENDOR_IF;
      send_event(setup_req(kind, ($urandom_range(7) == 0) ? 8'($urandom) : VENDOR_REQ,
                           8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
      repeat ($urandom_range(5)) send_event(bus_event(EV_IN_DONE));
      send_event(bus_event(EV_OUT_DONE));
    end else if (pick < 65) begin
      if ($urandom_range(1)) send_event(bus_event(EV_BUS_RESET));
      if ($urandom_range(3) != 0) begin
        send_event(setup_req(8'($urandom) & ~RT_TYPE_MASK, REQ_SET_ADDRESS, 8'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom)));
      end
      case ($urandom_range(3))
        0: vl = 8'd0;
        1, 2: vl = 8'd1;
        default: vl = 8'($urandom);
      endcase
      send_event(setup_req(8'($urandom) & ~RT_TYPE_MASK, REQ_SET_CONFIG, vl,
                           8'($urandom), 8'($urandom), 8'($urandom)));
      send_event(setup_req(std_kind(), REQ_GET_CONFIG, 8'($urandom), 8'($urandom),
                           8'($urandom), 8'($urandom)));
    end else if (pick < 80) begin
      case ($urandom_range(3))
        0: kind = RT_STD_IN_DEV;
        1: kind = RT_STD_IN_IF;
        2: kind = RT_STD_IN_EP;
        default: kind = 8'($urandom) & ~RT_TYPE_MASK;
      endcase
      case ($urandom_range(3))
        0: vl = 8'h00;
        1: vl = 8'h81;
        2: vl = 8'h01;
        default: vl = 8'($urandom);
      endcase
      send_event(setup_req(kind, REQ_GET_STATUS, 8'($urandom), 8'($urandom), vl,
                           8'($urandom)));
    end else if (pick < 88) begin
      kind = (8'($urandom) & ~RT_TYPE_MASK) | RT_TYPE_CLASS;
      send_event(setup_req(kind, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           $urandom_range(3) == 0 ? 8'd0 : 8'($urandom)));
      if ($urandom_range(1)) send_event(bus_event(EV_OUT_DONE));
      send_event(setup_req(std_kind(), $urandom_range(1) ? REQ_GET_INTERFACE : 8'($urandom),
                           8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
    end else begin
      repeat ($urandom_range(1, 3)) send_event(random_event());
    end
  endtask

  initial begin
    ep0_event_t ev;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    len_plan[REG_DEVICE_LEN] = 8'd18;
    len_plan[REG_CONFIG_LEN] = 8'd255;
    len_plan[REG_LANG_LEN]   = 8'd4;
    len_plan[REG_STR1_LEN]   = 8'd0;
    len_plan[REG_STR2_LEN]   = 8'd2;
    len_plan[REG_OS_STR_LEN] = 8'd18;
    len_plan[REG_COMPAT_LEN] = 8'd40;
    len_plan[REG_PROPS_LEN]  = 8'd255;
    write_desc_lengths();

    // default state: status and configuration reads stall
    send_event(setup_req(RT_STD_IN_DEV, REQ_GET_STATUS, 8'd0, 8'd0, 8'd0, 8'd2));
    send_event(setup_req(RT_STD_IN_DEV, REQ_GET_CONFIG, 8'd0, 8'd0, 8'd0, 8'd1));
    // short descriptor, then a long one split over several packets
    send_event(setup_req(RT_STD_IN_DEV, REQ_GET_DESCRIPTOR, 8'd0, DT_DEVICE, 8'd0, 8'hFF));
    send_event(bus_event(EV_IN_DONE));
    send_event(setup_req(RT_STD_IN_DEV, REQ_GET_DESCRIPTOR, 8'd0, DT_CONFIG, 8'd0, 8'hFF));
    repeat (4) send_event(bus_event(EV_IN_DONE));
    // empty string, os string, unknown string index, interface-power and unknown types
    send_event(setup_req(RT_STD_IN_DEV, REQ_GET_DESCRIPTOR, STR_ONE, DT_STRING, 8'd0, 8'hFF));
    send_event(setup_req(RT_STD_IN_DEV, REQ_GET_DESCRIPTOR, STR_OS, DT_STRING, 8'd0, 8'd8));
    send_event(setup_req(RT_STD_IN_DEV, REQ_GET_DESCRIPTOR, 8'h05, DT_STRING, 8'd0, 8'hFF));
    send_event(setup_req(RT_STD_IN_DEV, REQ_GET_DESCRIPTOR, 8'd0, DT_IF_POWER, 8'd0, 8'hFF));
    send_event(setup_req(RT_STD_IN_DEV, REQ_GET_DESCRIPTOR, 8'd0, 8'hFF, 8'd0, 8'hFF));
    // enumeration through addressed and configured
    send_event(setup_req(8'h00, REQ_SET_ADDRESS, 8'h7F, 8'd0, 8'd0, 8'd0));
    send_event(setup_req(RT_STD_IN_DEV, REQ_GET_STATUS, 8'd0, 8'd0, 8'd0, 8'd2));
    send_event(setup_req(8'h00, REQ_SET_CONFIG, 8'd1, 8'd0, 8'd0, 8'd0));
    send_event(setup_req(RT_STD_IN_DEV, REQ_GET_CONFIG, 8'd0, 8'd0, 8'd0, 8'd1));
    ev = setup_req(RT_STD_IN_EP, REQ_GET_STATUS, 8'd0, 8'd0, 8'h81, 8'd2);
    ev.in_ep_status = 8'hFF;
    ev.out_ep_status = 8'h00;
    send_event(ev);
    ev.index_low = 8'h01;
    send_event(ev);
    send_event(setup_req(8'h00, REQ_SET_CONFIG, 8'd2, 8'd0, 8'd0, 8'd0));
    send_event(setup_req(RT_STD_IN_IF, REQ_GET_INTERFACE, 8'd0, 8'd0, 8'd0, 8'd1));
    send_event(setup_req(RT_TYPE_CLASS, 8'h09, 8'd0, 8'd0, 8'd0, 8'hFF));
    send_event(setup_req(RT_VENDOR_DEV, VENDOR_REQ, 8'd0, 8'd0, 8'd4, 8'hFF));
    send_event(setup_req(RT_VENDOR_IF, VENDOR_REQ, 8'd0, 8'd0, 8'd5, 8'hFF));
    send_event(bus_event(EV_OUT_DONE));
    send_event(bus_event(EV_SETUP_TOKEN));
    send_event(bus_event(EV_BUS_RESET));
    send_event(bus_event(EV_FRAME));
    send_event(bus_event(EV_OTHER));
    drain_actions();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (phase == 0) len_plan[i] = 8'hFF;
        else if (phase == 1) len_plan[i] = 8'h00;
        else if ($urandom_range(3) == 0) len_plan[i] = $urandom_range(1) ? 8'hFF : 8'h00;
        else len_plan[i] = 8'($urandom);
      end
      write_desc_lengths();
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      while (events_sent < (phase + 1) * EVENTS_PER_PHASE) random_session();
      drain_actions();
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end

    repeat (8) @(posedge clk);
    board.report_leftovers();
    $display("ran %0d endpoint-0 events plus %0d ignored ones under %0d length settings",
             events_sent, events_ignored, settings_used);
    $display("%0d actions compared, %0d field mismatches", board.checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
